// ===== hw/rtl/att_pkg.sv =====
// att_pkg: shared types, request and status codes for the allocation tracking table
// used by att_front, att_cmdq, att_back and allocation_tracking_table
`default_nettype none

package att_pkg;

    // default number of table slots
    localparam int TABLE_DEPTH_DEF = 32;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // request codes
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_MISMATCH  = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_LEAK      = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    // request item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] address;
        logic [31:0] block_size;
        logic        is_array;
        logic [19:0] source_line;
    } req_t;

    // result item
    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] entry_address;
        logic [31:0] entry_size;
        logic        entry_is_array;
        logic [19:0] entry_line;
        logic        last;
    } rsp_t;

    // one stored allocation record
    typedef struct packed {
        logic [47:0] address;
        logic [31:0] size;
        logic        is_array;
        logic [19:0] line;
    } entry_t;

    // command classes decided by the front
    typedef enum logic [2:0] {
        CMD_ALLOC,
        CMD_ECHO,
        CMD_FREE,
        CMD_MISS,
        CMD_REPORT
    } cmd_kind_t;

    // classified command handed to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [47:0] address;
        logic [31:0] block_size;
        logic        is_array;
        logic [19:0] source_line;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/att_front.sv =====
// att_front: request register and classification into table commands
// depends on att_pkg
`default_nettype none

module att_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire att_pkg::req_t req_data,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output att_pkg::cmd_t      cmd_data
);

    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    att_pkg::cmd_t     cmd_reg;
    att_pkg::cmd_t     cmd_next;
    att_pkg::cmd_kind_t kind;
    logic              kind_ok;
    logic              accept;

    // hold off new requests only while the held command cannot move on
    assign req_stall = cmd_valid_reg && !cmd_ready;
    assign accept    = req_valid && !req_stall;

    // classify the request; zero addresses never reach the table
    always_comb
    begin
        kind_ok = 1'b1;
        kind    = att_pkg::CMD_ALLOC;
        case (req_data.req_type)
            att_pkg::REQ_ALLOC:
            begin
                kind = (req_data.address == 48'd0) ? att_pkg::CMD_ECHO : att_pkg::CMD_ALLOC;
            end
            att_pkg::REQ_FREE:
            begin
                kind = (req_data.address == 48'd0) ? att_pkg::CMD_MISS : att_pkg::CMD_FREE;
            end
            att_pkg::REQ_REPORT:
            begin
                kind = att_pkg::CMD_REPORT;
            end
            default:
            begin
                kind_ok = 1'b0;
            end
        endcase
    end

    // next command and its valid flag
    always_comb
    begin
        cmd_next.kind        = kind;
        cmd_next.address     = req_data.address;
        cmd_next.block_size  = req_data.block_size;
        cmd_next.is_array    = req_data.is_array;
        cmd_next.source_line = req_data.source_line;
        if (accept && kind_ok)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept && kind_ok)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/att_cmdq.sv =====
// att_cmdq: short command queue between the front and the table engine
// depends on att_pkg
`default_nettype none

module att_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire att_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop,
    output att_pkg::cmd_t      pop_data
);

    localparam int DEPTH = att_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    att_pkg::cmd_t    q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/att_back.sv =====
// att_back: table engine; slot memory, valid bits, slot scan and result register
// depends on att_pkg
`default_nettype none

module att_back #(
    parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    input  wire att_pkg::cmd_t cmd_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output att_pkg::rsp_t      rsp_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                 state_reg;
    att_pkg::cmd_t          cmd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   chk_vld_reg;
    att_pkg::entry_t        rd_data_reg;
    logic                   out_valid_reg;
    att_pkg::rsp_t          out_reg;
    att_pkg::entry_t        slot_mem [TABLE_DEPTH];

    logic             scan;
    logic             out_free;
    logic             at_end;
    logic [IDX_W-1:0] idx;
    logic             chk_hit;
    logic             addr_match;
    logic             kind_diff;
    logic             res_fire;
    att_pkg::rsp_t    res;
    logic             done;
    logic             stage_free;
    logic             issue;
    logic             wr_en;
    logic             clr_en;
    att_pkg::entry_t  wr_entry;

    assign scan       = (state_reg == S_SCAN);
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign at_end     = (rd_idx_reg == CNT_W'(TABLE_DEPTH));
    assign idx        = rd_idx_reg[IDX_W-1:0];
    assign chk_hit    = chk_vld_reg && valid_reg[chk_idx_reg];
    assign addr_match = (rd_data_reg.address == cmd_reg.address);
    assign kind_diff  = (rd_data_reg.is_array != cmd_reg.is_array);
    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;

    assign wr_entry.address  = cmd_reg.address;
    assign wr_entry.size     = cmd_reg.block_size;
    assign wr_entry.is_array = cmd_reg.is_array;
    assign wr_entry.line     = cmd_reg.source_line;

    // per-cycle scan decision: one slot issued, one slot checked
    always_comb
    begin
        res        = '0;
        res.last   = 1'b1;
        res_fire   = 1'b0;
        done       = 1'b0;
        stage_free = 1'b0;
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        case (cmd_reg.kind)
            att_pkg::CMD_ECHO:
            begin
                res.status         = att_pkg::ST_OK;
                res.entry_address  = cmd_reg.address;
                res.entry_size     = cmd_reg.block_size;
                res.entry_is_array = cmd_reg.is_array;
                res.entry_line     = cmd_reg.source_line;
                res_fire           = scan && out_free;
                done               = res_fire;
            end
            att_pkg::CMD_MISS:
            begin
                res.status        = att_pkg::ST_NOT_ALLOC;
                res.entry_address = cmd_reg.address;
                res_fire          = scan && out_free;
                done              = res_fire;
            end
            att_pkg::CMD_ALLOC:
            begin
                res.status         = at_end ? att_pkg::ST_FULL : att_pkg::ST_OK;
                res.entry_address  = cmd_reg.address;
                res.entry_size     = cmd_reg.block_size;
                res.entry_is_array = cmd_reg.is_array;
                res.entry_line     = cmd_reg.source_line;
                if (at_end || !valid_reg[idx])
                begin
                    res_fire = scan && out_free;
                    done     = res_fire;
                    wr_en    = res_fire && !at_end;
                end
                else
                begin
                    stage_free = 1'b1;
                end
            end
            att_pkg::CMD_FREE:
            begin
                if (chk_hit && addr_match)
                begin
                    res.status         = kind_diff ? att_pkg::ST_MISMATCH : att_pkg::ST_OK;
                    res.entry_address  = rd_data_reg.address;
                    res.entry_size     = rd_data_reg.size;
                    res.entry_is_array = rd_data_reg.is_array;
                    res.entry_line     = rd_data_reg.line;
                    res_fire           = scan && out_free;
                    done               = res_fire;
                    clr_en             = res_fire && !kind_diff;
                end
                else if (!chk_vld_reg && at_end)
                begin
                    res.status        = att_pkg::ST_NOT_ALLOC;
                    res.entry_address = cmd_reg.address;
                    res_fire          = scan && out_free;
                    done              = res_fire;
                end
                else
                begin
                    stage_free = 1'b1;
                end
            end
            att_pkg::CMD_REPORT:
            begin
                if (chk_hit)
                begin
                    res.status         = att_pkg::ST_LEAK;
                    res.entry_address  = rd_data_reg.address;
                    res.entry_size     = rd_data_reg.size;
                    res.entry_is_array = rd_data_reg.is_array;
                    res.entry_line     = rd_data_reg.line;
                    res.last           = 1'b0;
                    res_fire           = scan && out_free;
                    stage_free         = res_fire;
                end
                else if (!chk_vld_reg && at_end)
                begin
                    res.status = att_pkg::ST_DONE;
                    res_fire   = scan && out_free;
                    done       = res_fire;
                end
                else
                begin
                    stage_free = 1'b1;
                end
            end
            default:
            begin
                done = scan;
            end
        endcase
        issue = scan && stage_free && !at_end && !done;
    end

    // state, scan pointers, valid bits and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rd_idx_reg    <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg   <= S_SCAN;
                        rd_idx_reg  <= '0;
                        chk_vld_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                    end
                    if (issue)
                    begin
                        chk_idx_reg <= idx;
                        chk_vld_reg <= 1'b1;
                        rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                    end
                    else if (stage_free)
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (res_fire)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
    end

    // slot memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[idx] <= wr_entry;
        end
        if (issue)
        begin
            rd_data_reg <= slot_mem[idx];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/allocation_tracking_table.sv =====
// allocation_tracking_table: top level joining front, command queue and table engine
// depends on att_pkg, att_front, att_cmdq, att_back
`default_nettype none

// Tracks up to TABLE_DEPTH allocation records. Requests go through a front
// register and a two-entry command queue into a table engine that walks the
// slot memory one slot per cycle, unless a report waits on a stalled result
// side, through its single read port. An allocate stops at the lowest free
// slot, a free at the first matching slot, and a report walks every slot; an
// allocate or free of address zero is answered without walking the table.
// Requests of type three are dropped with no result. A report returns one
// leak result per valid slot in slot order with last low, then a done result
// with last high. No clearing pass is needed after reset: only the valid bits
// are cleared.
module allocation_tracking_table #(
    parameter int TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire att_pkg::req_t req_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output att_pkg::rsp_t      rsp_data
);

    logic          f_valid;
    logic          f_ready;
    att_pkg::cmd_t f_data;
    logic          q_valid;
    logic          q_pop;
    att_pkg::cmd_t q_data;

    // request register and classification
    att_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    // command queue
    att_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    // table engine
    att_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd_data  (q_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    // the engine only takes a command that the queue holds
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("command taken from an empty queue");

    // only leak results leave last low
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> rsp_data.status == att_pkg::ST_LEAK)
        else $error("non-final result with a status other than leak");

    // a done marker always closes its report
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == att_pkg::ST_DONE |-> rsp_data.last)
        else $error("report done without last");
`endif

endmodule

`default_nettype wire

// ===== test/tb_allocation_tracking_table.sv =====
// tb_allocation_tracking_table: self-checking testbench for the allocation tracking table
// depends on att_pkg and allocation_tracking_table; predicts every result and checks it
// with random idling on both the request and the result side

module tb_allocation_tracking_table;
    timeunit 1ns;
    timeprecision 1ps;

    import att_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT = 38;
    localparam int RANDOM_ITEMS = 380;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_SHOWN = 10;
    localparam int POOL_SIZE = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    // no idling on either side while set
    logic steady = 1'b0;

    // predicted table contents
    logic   slot_live [TABLE_DEPTH];
    entry_t slot_rec [TABLE_DEPTH];

    rsp_t expected_rsps [$];
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    allocation_tracking_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge clk)
    begin
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // expected table contents after reset
    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_live[i] = 1'b0;
            slot_rec[i]  = '0;
        end
    end

    // work out the results of one accepted request and update the table copy
    task automatic predict_request(input req_t item);
        rsp_t r;
        int   hit;
        hit = -1;
        r = '0;
        r.last = 1'b1;
        case (item.req_type)
            REQ_ALLOC:
            begin
                r.status         = ST_OK;
                r.entry_address  = item.address;
                r.entry_size     = item.block_size;
                r.entry_is_array = item.is_array;
                r.entry_line     = item.source_line;
                // address zero is echoed but never recorded
                if (item.address != '0)
                begin
                    for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
                        if (!slot_live[i])
                            hit = i;
                    if (hit < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_live[hit] = 1'b1;
                        slot_rec[hit]  = '{item.address, item.block_size,
                                           item.is_array, item.source_line};
                    end
                end
                expected_rsps.push_back(r);
            end
            REQ_FREE:
            begin
                for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
                    if (slot_live[i] && slot_rec[i].address == item.address)
                        hit = i;
                if (hit < 0)
                begin
                    r.status        = ST_NOT_ALLOC;
                    r.entry_address = item.address;
                end
                else
                begin
                    r.entry_address  = slot_rec[hit].address;
                    r.entry_size     = slot_rec[hit].size;
                    r.entry_is_array = slot_rec[hit].is_array;
                    r.entry_line     = slot_rec[hit].line;
                    // a kind mismatch keeps the entry
                    if (slot_rec[hit].is_array != item.is_array)
                        r.status = ST_MISMATCH;
                    else
                    begin
                        r.status = ST_OK;
                        slot_live[hit] = 1'b0;
                    end
                end
                expected_rsps.push_back(r);
            end
            REQ_REPORT:
            begin
                // one leak per live slot in slot order, then the done marker
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot_live[i])
                    begin
                        r = '0;
                        r.status         = ST_LEAK;
                        r.entry_address  = slot_rec[i].address;
                        r.entry_size     = slot_rec[i].size;
                        r.entry_is_array = slot_rec[i].is_array;
                        r.entry_line     = slot_rec[i].line;
                        expected_rsps.push_back(r);
                    end
                end
                r = '0;
                r.status = ST_DONE;
                r.last   = 1'b1;
                expected_rsps.push_back(r);
            end
            default:
            begin
                // unused request code: dropped without a result
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected st %0d addr %h size %h arr %b line %h last %b",
                     want.status, want.entry_address, want.entry_size,
                     want.entry_is_array, want.entry_line, want.last);
            $display("  actual   st %0d addr %h size %h arr %b line %h last %b",
                     got.status, got.entry_address, got.entry_size,
                     got.entry_is_array, got.entry_line, got.last);
        end
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            report_mismatch("result with nothing expected", '0, got);
            return;
        end
        want = expected_rsps.pop_front();
        if (got.status !== want.status || got.entry_address !== want.entry_address
            || got.entry_size !== want.entry_size
            || got.entry_is_array !== want.entry_is_array
            || got.entry_line !== want.entry_line || got.last !== want.last)
            report_mismatch("result differs", want, got);
    endtask

    // result transfers happen at the next rising edge; sample between edges
    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp_data);
    end

    // watchdog on cycles with no transfer on either side
    always @(negedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("allocation_tracking_table: mismatch");
            $finish;
        end
    end

    function automatic req_t build_request(input logic [1:0] kind, input logic [47:0] addr,
                                           input logic [31:0] size, input logic arr,
                                           input logic [19:0] line);
        req_t r;
        r.req_type    = kind;
        r.address     = addr;
        r.block_size  = size;
        r.is_array    = arr;
        r.source_line = line;
        return r;
    endfunction

    function automatic logic [47:0] random_address();
        logic [47:0] a;
        do
            a = 48'({$urandom, $urandom});
        while (a == '0);
        return a;
    endfunction

    // a live slot picked at random, or -1 when the table is empty
    function automatic int pick_live_slot();
        int start;
        int idx;
        start = $urandom_range(TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            idx = (start + i) % TABLE_DEPTH;
            if (slot_live[idx])
                return idx;
        end
        return -1;
    endfunction

    // one request transfer, called and returning at a rising edge
    task automatic send_request(input req_t item);
        logic stalled;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end
        while (stalled);
        predict_request(item);
    endtask

    // field extremes, every request kind and each special case
    task automatic test_directed_cases();
        logic [47:0] max_addr;
        max_addr = '1;
        send_request(build_request(REQ_ALLOC, max_addr, '1, 1'b1, '1));
        send_request(build_request(REQ_ALLOC, 48'd1, '0, 1'b0, '0));
        send_request(build_request(REQ_ALLOC, '0, 32'd123, 1'b1, 20'd5));
        send_request(build_request(REQ_ALLOC, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0,
                                   20'hAAAAA));
        send_request(build_request(REQ_REPORT, '0, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, '0, '1, 1'b1, '1));
        send_request(build_request(REQ_FREE, max_addr, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, 48'd1, '0, 1'b1, '0));
        send_request(build_request(REQ_FREE, 48'd1, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, 48'd1, '0, 1'b0, '0));
        send_request(build_request(REQ_UNUSED, max_addr, '1, 1'b1, '1));
        send_request(build_request(REQ_ALLOC, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b1,
                                   20'h55555));
        // same address twice with different kinds: the lower slot is found first
        send_request(build_request(REQ_ALLOC, 48'd7, 32'd16, 1'b1, 20'd70));
        send_request(build_request(REQ_ALLOC, 48'd7, 32'd32, 1'b0, 20'd71));
        send_request(build_request(REQ_REPORT, max_addr, '1, 1'b1, '1));
        send_request(build_request(REQ_FREE, 48'd7, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, 48'd7, '0, 1'b1, '0));
        send_request(build_request(REQ_FREE, 48'd7, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, max_addr, '0, 1'b1, '0));
        send_request(build_request(REQ_FREE, 48'hAAAA_AAAA_AAAA, '0, 1'b0, '0));
        send_request(build_request(REQ_FREE, 48'h5555_5555_5555, '0, 1'b1, '0));
        send_request(build_request(REQ_REPORT, '0, '0, 1'b0, '0));
    endtask

    // fill every slot, overflow it, report the full table and empty it again
    task automatic test_table_full();
        int idx;
        repeat (TABLE_DEPTH + 3)
            send_request(build_request(REQ_ALLOC, random_address(), $urandom,
                                       1'($urandom), 20'($urandom)));
        send_request(build_request(REQ_REPORT, random_address(), $urandom, 1'b0, '0));
        repeat (TABLE_DEPTH + 8)
        begin
            idx = pick_live_slot();
            if (idx >= 0)
                send_request(build_request(REQ_FREE, slot_rec[idx].address, $urandom,
                                           slot_rec[idx].is_array, 20'($urandom)));
        end
        send_request(build_request(REQ_REPORT, '0, '0, 1'b0, '0));
    endtask

    // mostly matched allocate and free pairs from an address pool, plus noise
    task automatic test_random_traffic();
        logic [47:0] pool [POOL_SIZE];
        logic [47:0] addr;
        logic        arr;
        int          sent;
        int          pick;
        int          idx;
        req_t        item;
        sent = 0;
        for (int k = 0; k < POOL_SIZE; k++)
            pool[k] = random_address();
        while (sent < RANDOM_ITEMS)
        begin
            // a long stretch with no idling on either side
            steady <= (sent >= 160 && sent < 260);
            pick = $urandom_range(99);
            addr = pool[$urandom_range(POOL_SIZE - 1)];
            arr  = 1'($urandom);
            idx  = pick_live_slot();
            if (pick < 38)
            begin
                if ($urandom_range(99) < 12)
                    addr = random_address();
                else if ($urandom_range(99) < 4)
                    addr = '0;
                item = build_request(REQ_ALLOC, addr, $urandom, arr, 20'($urandom));
            end
            else if (pick < 72 && idx >= 0)
            begin
                // free a live entry, now and then with the wrong kind
                arr = slot_rec[idx].is_array;
                if ($urandom_range(99) < 12)
                    arr = !arr;
                item = build_request(REQ_FREE, slot_rec[idx].address, $urandom, arr,
                                     20'($urandom));
            end
            else if (pick < 84)
            begin
                if ($urandom_range(99) < 40)
                    addr = random_address();
                else if ($urandom_range(99) < 8)
                    addr = '0;
                item = build_request(REQ_FREE, addr, $urandom, arr, 20'($urandom));
            end
            else if (pick < 90)
                item = build_request(REQ_REPORT, random_address(), $urandom, arr,
                                     20'($urandom));
            else if (pick < 96 && idx >= 0)
                // allocate an address that is already live
                item = build_request(REQ_ALLOC, slot_rec[idx].address, $urandom, arr,
                                     20'($urandom));
            else
                item = build_request(REQ_UNUSED, random_address(), $urandom, arr,
                                     20'($urandom));
            send_request(item);
            if (item.req_type != REQ_UNUSED)
                sent++;
        end
        steady <= 1'b0;
    endtask

    // stop sending and let every expected result arrive
    task automatic drain_results();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_table_full();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0)
            $display("allocation_tracking_table: match");
        else
            $display("allocation_tracking_table: mismatch");
        $finish;
    end

endmodule
